FILE: rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 5;
    localparam int CODE_W         = 16;
    localparam int CNT_W          = 3;
    localparam int LAST_BIT_POS   = 7;
    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int SYMBOL_COUNT_DEF  = 256;
    localparam int FIFO_DEPTH     = 2;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] symbol;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } t_entry;

    typedef struct packed {
        logic              flush;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } t_cmd;

endpackage

FILE: rtl/hcbp_fifo.sv
// Small synchronous FIFO used between the packer stages and at the result side.
module hcbp_fifo import hcbp_pkg::*; #(
    parameter int DW    = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [DW-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [NUM_W-1:0] r_num, n_num;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_num == NUM_W'(DEPTH));
    assign o_empty = (r_num == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_num    = r_num;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_num = r_num + NUM_W'(1);
        end else if (rd_en && !wr_en) begin
            n_num = r_num - NUM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_num    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_num    <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/hcbp_front.sv
// Front end: accepts requests, owns the code table, forwards encode/flush commands.
module hcbp_front import hcbp_pkg::*; #(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_push,
    output t_cmd     o_cmd,
    input  logic     i_cmd_full
);

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CAP   = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int CMP_W = BYTE_W + 1;

    t_entry            r_mem [SYMBOL_COUNT];
    logic              r_valid [SYMBOL_COUNT];
    t_entry            r_rd;
    logic              r_stg_vld;
    logic              r_stg_flush;
    logic              r_stg_hit;

    logic              acc;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  sat_len;
    logic              need;
    logic              is_load;
    logic              is_enc;
    logic              is_flush;

    assign idx      = i_item.symbol[IDX_W-1:0];
    assign in_range = ({1'b0, i_item.symbol} < CMP_W'(SYMBOL_COUNT));
    assign sat_len  = (i_item.code_length > LEN_W'(CAP)) ? LEN_W'(CAP) : i_item.code_length;
    assign is_load  = (i_item.opcode == OP_LOAD);
    assign is_enc   = (i_item.opcode == OP_ENCODE);
    assign is_flush = (i_item.opcode == OP_FLUSH);

    // zero-length and missing entries produce no bits, so they are dropped here
    assign need       = r_stg_vld && (r_stg_flush || (r_stg_hit && (r_rd.length != '0)));
    assign o_full     = need && i_cmd_full;
    assign o_cmd_push = need && !i_cmd_full;
    assign acc        = i_push && !o_full;

    assign o_cmd.flush  = r_stg_flush;
    assign o_cmd.length = r_rd.length;
    assign o_cmd.code   = r_rd.code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld   <= 1'b0;
            r_stg_flush <= 1'b0;
            r_stg_hit   <= 1'b0;
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (acc) begin
                r_stg_vld   <= is_enc || is_flush;
                r_stg_flush <= is_flush;
                r_stg_hit   <= is_enc && in_range && r_valid[idx];
                if (is_load && in_range) begin
                    r_valid[idx] <= 1'b1;
                end
            end else if (!o_full) begin
                r_stg_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_load && in_range) begin
            r_mem[idx] <= '{length: sat_len, code: i_item.code_value};
        end
        if (acc && is_enc && in_range) begin
            r_rd <= r_mem[idx];
        end
    end

endmodule

FILE: rtl/hcbp_back.sv
// Back end: merges code bits into the byte accumulator and emits finished bytes.
module hcbp_back import hcbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_out_full,
    output logic              o_out_push,
    output t_out_item         o_out,
    input  logic              i_cfg_wr,
    input  logic [BYTE_W-1:0] i_cfg_data
);

    localparam int K_W = $clog2(BYTE_W + 1);

    logic [BYTE_W-1:0] r_pb, n_pb;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic [CODE_W-1:0] r_code, n_code;

    logic [K_W-1:0]    room;
    logic [K_W-1:0]    k;
    logic [LEN_W-1:0]  rem_after;
    logic [CODE_W-1:0] shifted;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] chunk;
    logic [BYTE_W-1:0] pb_sh;
    logic [BYTE_W-1:0] merged;
    logic              completes;
    logic [CNT_W-1:0]  fl_sh;

    // take as many bits as fit before the byte boundary
    assign room      = K_W'(BYTE_W) - K_W'(r_cnt);
    assign k         = (r_rem < LEN_W'(room)) ? K_W'(r_rem) : room;
    assign rem_after = r_rem - LEN_W'(k);
    assign shifted   = r_code >> rem_after;
    assign mask      = BYTE_W'((9'd1 << k) - 9'd1);
    assign chunk     = shifted[BYTE_W-1:0] & mask;
    assign pb_sh     = r_pb << (k - K_W'(1));
    // the first bit adds into the old LSB; the rest land in zeros
    assign merged    = pb_sh + chunk;
    assign completes = ((K_W'(r_cnt) + k) == K_W'(BYTE_W));
    assign fl_sh     = CNT_W'(LAST_BIT_POS) - r_cnt;

    always_comb begin
        n_pb       = r_pb;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        n_rem      = r_rem;
        n_code     = r_code;
        o_cmd_pop  = 1'b0;
        o_out_push = 1'b0;
        o_out      = '{out_byte: merged, last: (rem_after < LEN_W'(BYTE_W))};
        if (r_busy) begin
            if (!completes) begin
                n_pb   = merged << 1;
                n_cnt  = r_cnt + CNT_W'(k);
                n_rem  = rem_after;
                n_busy = (rem_after != '0);
            end else if (!i_out_full) begin
                o_out_push = 1'b1;
                n_pb       = '0;
                n_cnt      = '0;
                n_rem      = rem_after;
                n_busy     = (rem_after != '0);
            end
        end else if (!i_cmd_empty) begin
            if (i_cmd.flush) begin
                o_out = '{out_byte: r_pb << fl_sh, last: 1'b1};
                if (!i_out_full) begin
                    o_cmd_pop  = 1'b1;
                    o_out_push = 1'b1;
                    n_pb       = '0;
                    n_cnt      = '0;
                end
            end else begin
                o_cmd_pop = 1'b1;
                n_rem     = i_cmd.length;
                n_code    = i_cmd.code;
                n_busy    = 1'b1;
            end
        end
        if (i_cfg_wr) begin
            n_pb  = i_cfg_data;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb   <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pb   <= n_pb;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_code <= n_code;
    end

endmodule

FILE: rtl/huffman_code_bit_packer_unit.sv
// Top level of the Huffman code bit packer.
//
//   channel   direction  handshake                 payload
//   request   in         push / full               i_item (t_in_item)
//   result    out        empty / pop               o_result (t_out_item)
//   config    in         i_cfg_valid/o_cfg_ready   i_cfg_data (start accumulator)
//
// Load and flush pass the front end in one registered step; flush emits the
// accumulator as a byte. An encode's table entry is read into a register; the back
// end starts it and merges one run of code bits per step up to the next byte boundary
// (8 bits a cycle at most, while the output queue has room). Front and back stall
// independently through a two-entry command queue; results wait in a two-entry
// output queue. Reset clears the table valid bits and the accumulator; no clearing pass.
module huffman_code_bit_packer_unit import hcbp_pkg::*; #(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_in_item          i_item,
    output logic              empty,
    input  logic              pop,
    output t_out_item         o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BYTE_W-1:0] i_cfg_data
);

    logic      cmd_push;
    logic      cmd_full;
    logic      cmd_empty;
    logic      cmd_pop;
    t_cmd      cmd_in;
    t_cmd      cmd_out;
    logic      out_push;
    logic      out_full;
    t_out_item out_in;

    assign o_cfg_ready = 1'b1;

    hcbp_front #(
        .MAX_CODE_BITS(MAX_CODE_BITS),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_cmd_push(cmd_push),
        .o_cmd     (cmd_in),
        .i_cmd_full(cmd_full)
    );

    hcbp_fifo #(
        .DW   ($bits(t_cmd)),
        .DEPTH(FIFO_DEPTH)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_empty(cmd_empty),
        .o_data (cmd_out)
    );

    hcbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_empty(cmd_empty),
        .i_cmd      (cmd_out),
        .o_cmd_pop  (cmd_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out      (out_in),
        .i_cfg_wr   (i_cfg_valid),
        .i_cfg_data (i_cfg_data)
    );

    hcbp_fifo #(
        .DW   ($bits(t_out_item)),
        .DEPTH(FIFO_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (out_in),
        .o_full (out_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (o_result)
    );

endmodule

FILE: rtl/hcbp_checker.sv
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_checker import hcbp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input t_in_item          i_item,
    input logic              empty,
    input logic              pop,
    input t_out_item         o_result,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [BYTE_W-1:0] i_cfg_data
);

    // queues come out of reset empty and open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not idle after reset");

    // full can only rise right after a request was taken
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without a request");

    a_result_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result vanished");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_result))
        else $error("waiting result changed");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (.*);

FILE: bench/huffman_code_bit_packer_unit_tb.sv
// Self-checking testbench for the Huffman code bit packer unit.
module huffman_code_bit_packer_unit_tb;
    import hcbp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CODE_CAP    = (MAX_CODE_BITS_DEF < CODE_W) ? MAX_CODE_BITS_DEF : CODE_W;
    localparam int SETTLE_CYC  = 12;
    localparam int CYCLE_LIMIT = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    t_in_item          i_item;
    logic              empty;
    logic              pop;
    t_out_item         o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [BYTE_W-1:0] i_cfg_data;

    // Predictor state: code table, accumulator and start value
    bit                tbl_valid [SYMBOL_COUNT_DEF];
    bit [LEN_W-1:0]    tbl_len   [SYMBOL_COUNT_DEF];
    bit [CODE_W-1:0]   tbl_code  [SYMBOL_COUNT_DEF];
    bit [BYTE_W-1:0]   acc_bits;
    bit [CNT_W-1:0]    acc_count;
    bit [BYTE_W-1:0]   start_acc;

    t_out_item         packed_bytes_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int fail_count;
    int n_requests;
    int n_bytes_checked;
    int n_cfg_writes;
    int cycle_count;

    huffman_code_bit_packer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("huffman_code_bit_packer_unit regression: fail");
            $finish;
        end
    end

    // Expected bytes for one accepted request
    task automatic pack_request(input t_in_item req);
        logic [BYTE_W-1:0] made [3];
        logic [BYTE_W-1:0] sum;
        int n;
        int len;
        n = 0;
        case (req.opcode)
            OP_LOAD: begin
                tbl_valid[req.symbol] = 1'b1;
                tbl_len[req.symbol]   = (req.code_length > LEN_W'(CODE_CAP))
                                        ? LEN_W'(CODE_CAP) : req.code_length;
                tbl_code[req.symbol]  = req.code_value;
            end
            OP_ENCODE: begin
                if (tbl_valid[req.symbol]) begin
                    len = int'(tbl_len[req.symbol]);
                    for (int i = 0; i < len; i++) begin
                        sum = acc_bits + {7'd0, tbl_code[req.symbol][len-1-i]};
                        if (acc_count < LAST_BIT_POS) begin
                            acc_bits = sum << 1;
                            acc_count++;
                        end else begin
                            made[n]   = sum;
                            n++;
                            acc_bits  = '0;
                            acc_count = '0;
                        end
                    end
                end
            end
            OP_FLUSH: begin
                made[0]   = acc_bits << (LAST_BIT_POS - acc_count);
                n         = 1;
                acc_bits  = '0;
                acc_count = '0;
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++)
            packed_bytes_q.insert(packed_bytes_q.size(),
                                  t_out_item'{out_byte: made[k], last: (k == n - 1)});
    endtask

    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        pack_request(req);
        n_requests++;
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [7:0] sym,
                               input logic [4:0] len, input logic [15:0] code);
        send_request(t_in_item'{opcode: op, symbol: sym, code_length: len, code_value: code});
    endtask

    // Wait until all expected bytes are out, then let in-flight requests settle
    task automatic drain_results();
        push <= 1'b0;
        while (packed_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_start_acc(input logic [BYTE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        start_acc = value;
        acc_bits  = value;
        acc_count = '0;
        n_cfg_writes++;
    endtask

    function automatic t_in_item random_request();
        t_in_item req;
        int r;
        r = $urandom_range(99);
        req.symbol      = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(15));
        req.code_length = ($urandom_range(99) < 85) ? 5'($urandom_range(CODE_CAP))
                                                    : 5'($urandom_range(31));
        req.code_value  = 16'($urandom);
        if (r < 22)
            req.opcode = OP_LOAD;
        else if (r < 85)
            req.opcode = OP_ENCODE;
        else if (r < 97)
            req.opcode = OP_FLUSH;
        else
            req.opcode = OP_UNUSED;
        return req;
    endfunction

    // Result side: random pops, optional long hold-off, check against prediction
    initial begin
        t_out_item want;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                n_bytes_checked++;
                if (packed_bytes_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h last %0b",
                           o_result.out_byte, o_result.last);
                    fail_count++;
                end else begin
                    want = packed_bytes_q.pop_front();
                    if (o_result.out_byte !== want.out_byte) begin
                        $error("out_byte mismatch: expected %0h, got %0h",
                               want.out_byte, o_result.out_byte);
                        fail_count++;
                    end
                    if (o_result.last !== want.last) begin
                        $error("last mismatch: expected %0b, got %0b",
                               want.last, o_result.last);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic test_table_and_encode();
        send_fields(OP_ENCODE, 8'd5, 5'd3, 16'h0007);     // nothing loaded yet: skipped
        send_fields(OP_LOAD, 8'd0, 5'd0, 16'hFFFF);       // zero-length entry
        send_fields(OP_LOAD, 8'd255, 5'd16, 16'hFFFF);
        send_fields(OP_LOAD, 8'd1, 5'd1, 16'h0001);
        send_fields(OP_LOAD, 8'd2, 5'd8, 16'h00A5);
        send_fields(OP_LOAD, 8'd3, 5'd31, 16'h8001);      // saturates to max length
        send_fields(OP_LOAD, 8'd4, 5'd7, 16'hFF55);
        send_fields(OP_LOAD, 8'd6, 5'd17, 16'h0000);
        send_fields(OP_UNUSED, 8'hFF, 5'h1F, 16'hFFFF);   // ignored
        send_fields(OP_ENCODE, 8'd0, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd255, 5'h1F, 16'hFFFF);
        send_fields(OP_ENCODE, 8'd1, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd2, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd3, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd4, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd6, 5'd0, 16'h0000);
        send_fields(OP_FLUSH, 8'd0, 5'd0, 16'h0000);
        send_fields(OP_FLUSH, 8'hFF, 5'h1F, 16'hFFFF);    // nothing pending: zero byte
        send_fields(OP_LOAD, 8'd1, 5'd3, 16'h0005);       // replace an entry
        send_fields(OP_ENCODE, 8'd1, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd200, 5'd0, 16'h0000);   // never loaded
        send_fields(OP_FLUSH, 8'd0, 5'd0, 16'h0000);
        drain_results();
    endtask

    task automatic test_start_accumulator();
        write_start_acc(8'hFF);
        send_fields(OP_ENCODE, 8'd2, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd1, 5'd0, 16'h0000);
        send_fields(OP_FLUSH, 8'd0, 5'd0, 16'h0000);
        drain_results();
        write_start_acc(8'h81);
        send_fields(OP_FLUSH, 8'd0, 5'd0, 16'h0000);      // no bits yet: start value shifted
        drain_results();
        write_start_acc(8'h5A);
        send_fields(OP_ENCODE, 8'd4, 5'd0, 16'h0000);
        send_fields(OP_ENCODE, 8'd255, 5'd0, 16'h0000);
        send_fields(OP_FLUSH, 8'd0, 5'd0, 16'h0000);
        drain_results();
        write_start_acc(8'h00);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 200;
        for (int i = 0; i < 24; i++)
            send_fields(OP_ENCODE, (i % 3 == 0) ? 8'd3 : 8'd255, 5'd0, 16'h0000);
        send_fields(OP_FLUSH, 8'd0, 5'd0, 16'h0000);
        drain_results();
    endtask

    task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++)
            send_request(random_request());
        drain_results();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_and_encode();
        test_start_accumulator();
        test_output_backpressure();
        test_random_traffic(110, 11, 45);
        write_start_acc(8'($urandom_range(255)));
        test_random_traffic(110, 45, 11);
        write_start_acc(8'hFF);
        test_random_traffic(40, 0, 0);
        write_start_acc(8'h00);
        test_random_traffic(80, 0, 0);

        $display("Sent %0d requests (loads, encodes, flushes, unused codes); checked %0d bytes",
                 n_requests, n_bytes_checked);
        $display("Start accumulator written %0d times; output held off once to fill the block",
                 n_cfg_writes);
        if (fail_count == 0)
            $display("huffman_code_bit_packer_unit regression: pass");
        else
            $display("huffman_code_bit_packer_unit regression: fail");
        $finish;
    end

endmodule
